// File: hdl/singly_linked_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Singly linked list engine: assertion macros
// Shared macros for the concurrent checks of the list engine.
// ----------------------------------------------------------------------------
`ifndef SINGLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define SINGLY_LINKED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SLL_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SLL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hdl/sll_pkg.sv
// ----------------------------------------------------------------------------
// Singly linked list engine: package
// Opcodes, status codes, controller states and transaction structs.
// ----------------------------------------------------------------------------
package sll_pkg;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_COUNT   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_SHOW
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] item_value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] element;
      logic [6:0]         length;
      logic               last;
   } rsp_type;

   // Node pool commands from the controller
   typedef struct packed {
      logic do_alloc;
      logic do_free;
   } pool_ctrl_type;

endpackage

// File: hdl/sll_mem.sv
// ----------------------------------------------------------------------------
// Singly linked list engine: node memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sll_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sll_pool.sv
// ----------------------------------------------------------------------------
// Singly linked list engine: node pool
// Free map of the pool entries with a lowest-free-entry search.
// ----------------------------------------------------------------------------
module sll_pool #(
   parameter int CAPACITY = 16,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sll_pkg::pool_ctrl_type ctrl,
   input  logic [IDX_W-1:0]      free_idx,
   output logic [IDX_W-1:0]      free_slot,
   output logic                  none_free
);

   import sll_pkg::*;

   logic [CAPACITY-1:0] free_map_ff;
   logic [CAPACITY-1:0] free_map_in;

   // lowest free entry wins
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_map_ff[i]) begin
            free_slot = IDX_W'(i);
         end
      end
   end

   assign none_free = ~|free_map_ff;

   always_comb begin
      free_map_in = free_map_ff;
      if (ctrl.do_alloc) begin
         free_map_in[free_slot] = 1'b0;
      end
      if (ctrl.do_free) begin
         free_map_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
      end else begin
         free_map_ff <= free_map_in;
      end
   end

endmodule

// File: hdl/singly_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Singly linked list engine
// Bounded singly linked list over a node pool: append, delete, display, count.
// ----------------------------------------------------------------------------
// Usage:
//  - A request transaction (req_data) is taken on a clock edge with start high
//    and busy low. busy stays high while a delete walk or a display runs.
//  - Each response transaction sits on rsp_data for one cycle with rsp_valid
//    high. The receiver cannot stall; every response must be taken as shown.
//  - Append, count and any rejected request: one response, in the cycle after
//    the request; busy never rises. A new request may follow at once.
//  - Delete at position p: the link memory is walked one node per cycle, and
//    the response is registered once node p is reached; busy is high meanwhile.
//  - Display of n nodes: n responses on consecutive cycles, the first after the
//    head node read and the response register, last set on the final one.
//  - Throughput is set by the link memory read: one node per cycle; no new
//    request is taken while a delete walk or a display runs.
//  - Synchronous reset empties the list and marks every pool entry free; the
//    node memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "singly_linked_list_engine_defines.svh"

module singly_linked_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sll_pkg::req_type req_data,
   output logic             rsp_valid,
   output sll_pkg::rsp_type rsp_data
);

   import sll_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // controller state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic               prev_ok_ff, prev_ok_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memory and pool ports
   logic               val_we;
   logic [IDX_W-1:0]   val_waddr;
   logic [31:0]        val_wdata;
   logic [31:0]        val_rdata;
   logic               lnk_we;
   logic [IDX_W-1:0]   lnk_waddr;
   logic [IDX_W-1:0]   lnk_wdata;
   logic [IDX_W-1:0]   lnk_rdata;
   logic [IDX_W-1:0]   rd_addr;
   pool_ctrl_type      pool_ctrl;
   logic [IDX_W-1:0]   free_slot;
   logic               none_free;

   logic               accept;
   logic               list_empty;
   logic               del_valid;
   logic               walk_done;
   logic               show_done;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start & ~busy;
   assign list_empty = (count_ff == '0);
   // position nonzero, list non-empty, position within the length
   assign del_valid  = (req_data.position != 7'd0) && !list_empty &&
                       (req_data.position <= 7'(count_ff));
   assign walk_done  = (remain_ff == '0);
   assign show_done  = (remain_ff == CNT_W'(1));

   // Value and link stores. Writes only happen on the accept cycle of an
   // append or the final cycle of a delete, and every read comes on a later
   // edge, so no forwarding is needed.
   sll_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (32)
   ) u_val_mem (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   sll_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (IDX_W)
   ) u_lnk_mem (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (rd_addr),
      .rd_data (lnk_rdata)
   );

   sll_pool #(
      .CAPACITY (CAPACITY)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pool_ctrl),
      .free_idx  (cur_ff),
      .free_slot (free_slot),
      .none_free (none_free)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_DELETE && del_valid) begin
                  state_in = S_WALK;
               end else if (req_data.opcode == OP_DISPLAY && !list_empty) begin
                  state_in = S_SHOW;
               end
            end
         end
         S_WALK: begin
            if (walk_done) begin
               state_in = S_IDLE;
            end
         end
         S_SHOW: begin
            if (show_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, memory and pool controls, responses
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_ok_in   = prev_ok_ff;
      remain_in    = remain_ff;
      val_we       = 1'b0;
      val_waddr    = free_slot;
      val_wdata    = req_data.item_value;
      lnk_we       = 1'b0;
      lnk_waddr    = tail_ff;
      lnk_wdata    = free_slot;
      rd_addr      = cur_ff;
      pool_ctrl    = '0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '{status: ST_OK, element: '0, length: 7'(count_ff), last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (none_free) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        // the tail's own link is never followed, so it is
                        // left unwritten until the next append
                        val_we             = 1'b1;
                        lnk_we             = !list_empty;
                        pool_ctrl.do_alloc = 1'b1;
                        if (list_empty) begin
                           head_in = free_slot;
                        end
                        tail_in            = free_slot;
                        count_in           = count_ff + CNT_W'(1);
                        rsp_data_in.length = 7'(count_in);
                     end
                  end
                  OP_DELETE: begin
                     if (req_data.position == 7'd0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = ST_INVALID;
                     end else if (list_empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = ST_EMPTY;
                     end else if (!del_valid) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = ST_INVALID;
                     end else begin
                        rd_addr    = head_ff;
                        cur_in     = head_ff;
                        prev_ok_in = 1'b0;
                        remain_in  = CNT_W'(req_data.position - 7'd1);
                     end
                  end
                  OP_DISPLAY: begin
                     if (list_empty) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        rd_addr   = head_ff;
                        remain_in = count_ff;
                     end
                  end
                  OP_COUNT: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            // lnk_rdata holds the link of cur_ff
            if (walk_done) begin
               if (prev_ok_ff) begin
                  lnk_we    = 1'b1;
                  lnk_waddr = prev_ff;
                  lnk_wdata = lnk_rdata;
               end else begin
                  head_in = lnk_rdata;
               end
               if (tail_ff == cur_ff) begin
                  tail_in = prev_ff;
               end
               pool_ctrl.do_free  = 1'b1;
               count_in           = count_ff - CNT_W'(1);
               rsp_valid_in       = 1'b1;
               rsp_data_in.length = 7'(count_in);
            end else begin
               prev_in    = cur_ff;
               prev_ok_in = 1'b1;
               cur_in     = lnk_rdata;
               rd_addr    = lnk_rdata;
               remain_in  = remain_ff - CNT_W'(1);
            end
         end
         S_SHOW: begin
            rsp_valid_in        = 1'b1;
            rsp_data_in.element = val_rdata;
            rsp_data_in.last    = show_done;
            rd_addr             = lnk_rdata;
            remain_in           = remain_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // head and tail are only meaningful while the count is nonzero
   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_ok_ff  <= prev_ok_in;
      remain_ff   <= remain_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `SLL_ASSERT_IMPL(a_pool_matches_count, 1'b1, none_free == (count_ff == CAPACITY), "pool and count disagree")
   `SLL_ASSERT_NEXT(a_append_answers, accept && req_data.opcode == OP_APPEND, rsp_valid && rsp_data.last, "append without response")
   `SLL_ASSERT_IMPL(a_last_frees_engine, rsp_valid && rsp_data.last, state_ff == S_IDLE, "final response while busy")
   `SLL_ASSERT_IMPL(a_partial_only_in_show, rsp_valid && !rsp_data.last, state_ff == S_SHOW, "non-final response outside display")

endmodule

// File: bench/tb_singly_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Singly linked list engine: self-checking testbench
// Drives append, delete, display and count transactions through the command
// port, predicts every response from a value queue that mirrors the list, and
// checks each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_singly_linked_list_engine;
   import sll_pkg::*;

   localparam int CAPACITY     = 16;
   // longest single transactions: a full display or a delete of the tail, plus setup
   localparam int DRAIN_CYCLES = CAPACITY + 8;
   localparam int RANDOM_OPS   = 47;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Values in list order, head first. Pool slot numbering never shows on the
   // response port, so the order of values is all the prediction needs.
   logic signed [31:0] list_vals[$];
   // Responses still owed by the engine, oldest first
   rsp_type            due_replies[$];
   int                 error_count;
   int                 idle_pct;     // chance per cycle that the sender holds off
   int                 grow_target;  // list length the random traffic drifts to

   singly_linked_list_engine #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // length always carries the node count after the operation
   function automatic rsp_type make_reply(status_type st, logic signed [31:0] elem,
                                          logic fin);
      rsp_type r;
      r.status  = st;
      r.element = elem;
      r.length  = 7'(list_vals.size());
      r.last    = fin;
      return r;
   endfunction

   // Applies one accepted transaction to the mirror list and queues the
   // responses it owes.
   function automatic void predict_list_op(req_type item);
      int pos;
      int len;
      pos = item.position;
      len = list_vals.size();
      case (item.opcode)
         OP_APPEND: begin
            if (len >= CAPACITY) begin
               // pool exhausted: nothing changes
               due_replies.push_back(make_reply(ST_FULL, '0, 1'b1));
            end else begin
               list_vals.push_back(item.item_value);
               due_replies.push_back(make_reply(ST_OK, '0, 1'b1));
            end
         end
         OP_DELETE: begin
            // position zero is rejected ahead of the empty check
            if (pos == 0) begin
               due_replies.push_back(make_reply(ST_INVALID, '0, 1'b1));
            end else if (len == 0) begin
               due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            end else if (pos > len) begin
               due_replies.push_back(make_reply(ST_INVALID, '0, 1'b1));
            end else begin
               list_vals.delete(pos - 1);
               due_replies.push_back(make_reply(ST_OK, '0, 1'b1));
            end
         end
         OP_DISPLAY: begin
            if (len == 0) begin
               due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
            end else begin
               for (int i = 0; i < len; i++)
                  due_replies.push_back(make_reply(ST_OK, list_vals[i], i == len - 1));
            end
         end
         OP_COUNT: begin
            due_replies.push_back(make_reply(ST_OK, '0, 1'b1));
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Response checking: the engine cannot be stalled, so every strobed beat is
   // taken on the edge that closes its cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      rsp_type exp_r;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_replies.size() == 0) begin
            $display("%0t: unexpected response status %0d element %0d length %0d last %0d",
                     $time, rsp_data.status, rsp_data.element, rsp_data.length,
                     rsp_data.last);
            error_count++;
         end else begin
            exp_r = due_replies.pop_front();
            if (rsp_data.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_r.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.element !== exp_r.element) begin
               $display("%0t: element expected %0d actual %0d",
                        $time, exp_r.element, rsp_data.element);
               error_count++;
            end
            if (rsp_data.length !== exp_r.length) begin
               $display("%0t: length expected %0d actual %0d",
                        $time, exp_r.length, rsp_data.length);
               error_count++;
            end
            if (rsp_data.last !== exp_r.last) begin
               $display("%0t: last expected %0d actual %0d",
                        $time, exp_r.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Transaction helpers
   // -------------------------------------------------------------------------

   function automatic req_type make_op(opcode_type op, logic signed [31:0] value,
                                       logic [6:0] pos);
      req_type item;
      item.opcode     = op;
      item.item_value = value;
      item.position   = pos;
      return item;
   endfunction

   // Presents one transaction and returns on the edge that accepts it.
   // start is left high so a following transaction goes back to back; it is
   // only lowered by a random hold-off or a pause.
   task automatic send_list_op(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      predict_list_op(item);
   endtask

   // Holds the sender off until every owed response has been seen
   task automatic wait_for_replies();
      start <= 1'b0;
      while (due_replies.size() != 0)
         @(posedge clock);
   endtask

   // Random traffic drifts between short and full lists; deletes mostly hit a
   // live node, the rest use any 7-bit position. Unused fields carry noise.
   function automatic req_type random_list_op();
      req_type item;
      int      len;
      int      roll;
      int      grow_w;
      int      drop_w;
      len = list_vals.size();
      if ($urandom_range(19) == 0)
         grow_target = $urandom_range(CAPACITY);
      item.item_value = $urandom;
      item.position   = 7'($urandom);
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(2))
            0: item.item_value = 32'sh8000_0000;
            1: item.item_value = 32'sh7FFF_FFFF;
            default: item.item_value = '0;
         endcase
      end
      grow_w = (len < grow_target) ? 65 : 20;
      drop_w = (len < grow_target) ? 15 : 50;
      roll   = $urandom_range(99);
      if (roll < grow_w) begin
         item.opcode = OP_APPEND;
      end else if (roll < grow_w + drop_w) begin
         item.opcode = OP_DELETE;
         if (len > 0 && $urandom_range(4) != 0)
            item.position = 7'($urandom_range(len, 1));
      end else if (roll < 90) begin
         item.opcode = OP_DISPLAY;
      end else begin
         item.opcode = OP_COUNT;
      end
      return item;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Delete, display and count against an empty list, including position zero
   task automatic test_empty_list();
      send_list_op(make_op(OP_DELETE, $urandom, 7'd0));
      send_list_op(make_op(OP_DELETE, $urandom, 7'd1));
      send_list_op(make_op(OP_DELETE, $urandom, 7'd127));
      send_list_op(make_op(OP_DISPLAY, $urandom, 7'($urandom)));
      send_list_op(make_op(OP_COUNT, $urandom, 7'($urandom)));
   endtask

   // Fill the pool, the first six with extreme values, then overflow it and list it
   task automatic test_fill_to_capacity();
      logic signed [31:0] seeds[6];
      seeds = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA};
      for (int i = 0; i < CAPACITY; i++)
         send_list_op(make_op(OP_APPEND, (i < 6) ? seeds[i] : $urandom, 7'($urandom)));
      send_list_op(make_op(OP_APPEND, 32'sh1234_5678, 7'($urandom)));
      send_list_op(make_op(OP_DISPLAY, $urandom, 7'($urandom)));
   endtask

   // Position zero and beyond the length on a full list, then tail, head and
   // a middle node
   task automatic test_delete_cases();
      send_list_op(make_op(OP_DELETE, $urandom, 7'd0));
      send_list_op(make_op(OP_DELETE, $urandom, 7'(CAPACITY + 1)));
      send_list_op(make_op(OP_DELETE, $urandom, 7'(CAPACITY)));
      send_list_op(make_op(OP_DELETE, $urandom, 7'd1));
      send_list_op(make_op(OP_DELETE, $urandom, 7'd7));
      send_list_op(make_op(OP_DISPLAY, $urandom, 7'($urandom)));
   endtask

   task automatic test_random_traffic(input int hold_pct);
      idle_pct = hold_pct;
      repeat (RANDOM_OPS)
         send_list_op(random_list_op());
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      error_count = 0;
      idle_pct    = 0;
      grow_target = CAPACITY;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_capacity();
      test_delete_cases();
      // let the engine drain completely before the random part
      wait_for_replies();

      test_random_traffic(13);
      test_random_traffic(88);
      test_random_traffic(0);

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: singly_linked_list_engine.f
+incdir+hdl
hdl/sll_pkg.sv
hdl/sll_mem.sv
hdl/sll_pool.sv
hdl/singly_linked_list_engine.sv
bench/tb_singly_linked_list_engine.sv
